/* design/cie94_pkg.sv */
package cie94_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // Field widths of the pixel pair and the result word
  localparam int L_W   = 15;
  localparam int AB_W  = 16;
  localparam int OUT_W = 16;

  // Internal widths
  localparam int SQ_W      = 31;  // square of one a*/b* code
  localparam int CRAD_W    = 32;  // a*a + b*b
  localparam int CHROMA_W  = CRAD_W / 2;
  localparam int DIFF_W    = AB_W + 1;
  localparam int DSQ_W     = 32;  // square of an a*/b* or chroma difference
  localparam int DAB_W     = DSQ_W + 1;
  localparam int DL_W      = L_W + 1;
  localparam int DL2_W     = 30;
  localparam int PK_W      = 28;  // chroma times a weight code
  localparam int QUO_W     = 34;  // weighted chroma and hue terms
  localparam int SUM_W     = 36;
  localparam int E_W       = SUM_W / 2;

  // Graphic-arts weights as unsigned Q0.16 codes
  localparam int WEIGHT_CW = 12;
  localparam logic [WEIGHT_CW-1:0] WEIGHT_K1 = 12'd2949;
  localparam logic [WEIGHT_CW-1:0] WEIGHT_K2 = 12'd983;
  localparam int WEIGHT_SHIFT = 16;
  localparam logic [PK_W-1:0] WEIGHT_ROUND = 28'd32768;

endpackage

/* design/cie94_sqrt_pipe.sv */
module cie94_sqrt_pipe #(
  parameter int LANES = 1,
  parameter int RAD_W = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [LANES-1:0][RAD_W-1:0]       radicand,
  output logic                              out_valid,
  output logic [LANES-1:0][RAD_W/2-1:0]     root
);

  localparam int STAGES = RAD_W / 2;
  localparam int HW     = RAD_W / 2;
  localparam int RMW    = HW + 3;

  logic [STAGES-1:0] v_r;
  logic [RMW-1:0]    rem_r    [STAGES][LANES];
  logic [HW-1:0]     root_r   [STAGES][LANES];
  logic [RAD_W-1:0]  rad_r    [STAGES][LANES];
  logic [RMW-1:0]    rem_nxt  [STAGES][LANES];
  logic [HW-1:0]     root_nxt [STAGES][LANES];
  logic [RAD_W-1:0]  rad_nxt  [STAGES][LANES];

  // One root bit per stage: take the next two radicand bits, try 4r+1
  always_comb begin
    logic [RMW-1:0]   rem_s;
    logic [HW-1:0]    root_s;
    logic [RAD_W-1:0] rad_s;
    logic [RMW-1:0]   rem_sh;
    logic [RMW-1:0]   trial;
    logic             ge;
    for (int k = 0; k < STAGES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          rem_s  = '0;
          root_s = '0;
          rad_s  = radicand[l];
        end else begin
          rem_s  = rem_r[k-1][l];
          root_s = root_r[k-1][l];
          rad_s  = rad_r[k-1][l];
        end
        rem_sh = {rem_s[RMW-3:0], rad_s[RAD_W-1 -: 2]};
        trial  = RMW'({root_s, 2'b01});
        ge     = (rem_sh >= trial);
        rem_nxt[k][l]  = ge ? (rem_sh - trial) : rem_sh;
        root_nxt[k][l] = {root_s[HW-2:0], ge};
        rad_nxt[k][l]  = {rad_s[RAD_W-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l]  <= rem_nxt[k][l];
          root_r[k][l] <= root_nxt[k][l];
          rad_r[k][l]  <= rad_nxt[k][l];
        end
      end
    end
  end

  assign out_valid = v_r[STAGES-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = root_r[STAGES-1][l];
    end
  end

endmodule

/* design/cie94_div_pipe.sv */
module cie94_div_pipe #(
  parameter int LANES = 1,
  parameter int NUM_W = 50,
  parameter int DEN_W = 26,
  parameter int QUO_W = 34
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]   num,
  input  logic [LANES-1:0][DEN_W-1:0]   den,
  output logic                          out_valid,
  output logic [LANES-1:0][QUO_W-1:0]   quotient
);

  logic [QUO_W-1:0] v_r;
  logic [DEN_W-1:0] rem_r   [QUO_W][LANES];
  logic [QUO_W-1:0] low_r   [QUO_W][LANES];
  logic [DEN_W-1:0] den_r   [QUO_W][LANES];
  logic [QUO_W-1:0] q_r     [QUO_W][LANES];
  logic [DEN_W-1:0] rem_nxt [QUO_W][LANES];
  logic [QUO_W-1:0] low_nxt [QUO_W][LANES];
  logic [DEN_W-1:0] den_nxt [QUO_W][LANES];
  logic [QUO_W-1:0] q_nxt   [QUO_W][LANES];

  // Restoring division, one quotient bit per stage; the top numerator
  // bits are below the divisor, so the quotient fits QUO_W bits
  always_comb begin
    logic [DEN_W-1:0] rem_s;
    logic [QUO_W-1:0] low_s;
    logic [DEN_W-1:0] den_s;
    logic [QUO_W-1:0] q_s;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          rem_s = DEN_W'(num[l] >> QUO_W);
          low_s = num[l][QUO_W-1:0];
          den_s = den[l];
          q_s   = '0;
        end else begin
          rem_s = rem_r[k-1][l];
          low_s = low_r[k-1][l];
          den_s = den_r[k-1][l];
          q_s   = q_r[k-1][l];
        end
        rem_sh = {rem_s, low_s[QUO_W-1]};
        ge     = (rem_sh >= {1'b0, den_s});
        rem_nxt[k][l] = DEN_W'(ge ? (rem_sh - {1'b0, den_s}) : rem_sh);
        low_nxt[k][l] = {low_s[QUO_W-2:0], 1'b0};
        den_nxt[k][l] = den_s;
        q_nxt[k][l]   = {q_s[QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          low_r[k][l] <= low_nxt[k][l];
          den_r[k][l] <= den_nxt[k][l];
          q_r[k][l]   <= q_nxt[k][l];
        end
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quotient[l] = q_r[QUO_W-1][l];
    end
  end

endmodule

/* design/cie94_color_difference_top.sv */
// Throughput: one pixel pair per cycle while in_stall is low; the depth
// comes from the 16-stage chroma root, the 34-stage divider and the
// 18-stage final root.
// Ready: in_stall rises only while the output skid register is full.
// Reset (rst_n low, synchronous) clears every valid bit and the output
// and skid registers; data registers are not reset.
module cie94_color_difference_top #(
  parameter int FRAC_BITS = cie94_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [cie94_pkg::L_W-1:0]     in_ref_lightness,
  input  logic signed [cie94_pkg::AB_W-1:0]    in_ref_green_red,
  input  logic signed [cie94_pkg::AB_W-1:0]    in_ref_blue_yellow,
  input  logic        [cie94_pkg::L_W-1:0]     in_cmp_lightness,
  input  logic signed [cie94_pkg::AB_W-1:0]    in_cmp_green_red,
  input  logic signed [cie94_pkg::AB_W-1:0]    in_cmp_blue_yellow,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [cie94_pkg::OUT_W-1:0]   out_delta_e,
  output logic                                 out_saturated
);

  import cie94_pkg::*;

  // SC and SH stay below 2^FRAC_BITS + 2086
  localparam int SW = (FRAC_BITS > 12) ? FRAC_BITS + 1 : 13;
  localparam int DW = 2 * SW;
  localparam int NW = QUO_W + 2 * FRAC_BITS;
  localparam int C_STAGES = CRAD_W / 2;
  localparam logic [SW-1:0] ONE_Q = SW'(1) << FRAC_BITS;

  // Global advance: the whole pipe moves while the skid register is empty
  logic adv;
  logic skid_v_r;
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // ---------------- Stage 1: component squares and differences
  logic                      v1_r;
  logic        [SQ_W-1:0]    sa1_r, sb1_r, sa2_r, sb2_r;
  logic signed [DIFF_W-1:0]  da_r, db_r;
  logic signed [DL_W-1:0]    dl_r;
  logic signed [31:0]        pa1, pb1, pa2, pb2;
  logic signed [DIFF_W-1:0]  da_nxt, db_nxt;
  logic signed [DL_W-1:0]    dl_nxt;

  assign pa1 = in_ref_green_red * in_ref_green_red;
  assign pb1 = in_ref_blue_yellow * in_ref_blue_yellow;
  assign pa2 = in_cmp_green_red * in_cmp_green_red;
  assign pb2 = in_cmp_blue_yellow * in_cmp_blue_yellow;
  assign da_nxt = DIFF_W'(in_ref_green_red) - DIFF_W'(in_cmp_green_red);
  assign db_nxt = DIFF_W'(in_ref_blue_yellow) - DIFF_W'(in_cmp_blue_yellow);
  assign dl_nxt = $signed({1'b0, in_ref_lightness}) - $signed({1'b0, in_cmp_lightness});

  always_ff @(posedge clk) begin
    if (adv) begin
      sa1_r <= pa1[SQ_W-1:0];
      sb1_r <= pb1[SQ_W-1:0];
      sa2_r <= pa2[SQ_W-1:0];
      sb2_r <= pb2[SQ_W-1:0];
      da_r  <= da_nxt;
      db_r  <= db_nxt;
      dl_r  <= dl_nxt;
    end
  end

  // ---------------- Stage 2: chroma radicands, difference squares
  logic                 v2_r;
  logic [CRAD_W-1:0]    r1_r, r2_r;
  logic [DSQ_W-1:0]     sda_r, sdb_r;
  logic [DL2_W-1:0]     dl2_r;
  logic signed [33:0]   pda, pdb;
  logic signed [31:0]   pdl;

  assign pda = da_r * da_r;
  assign pdb = db_r * db_r;
  assign pdl = dl_r * dl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_r  <= CRAD_W'(sa1_r) + CRAD_W'(sb1_r);
      r2_r  <= CRAD_W'(sa2_r) + CRAD_W'(sb2_r);
      sda_r <= pda[DSQ_W-1:0];
      sdb_r <= pdb[DSQ_W-1:0];
      dl2_r <= pdl[DL2_W-1:0];
    end
  end

  // ---------------- Stage 3: squared a/b distance
  logic                 v3_r;
  logic [CRAD_W-1:0]    r1_3_r, r2_3_r;
  logic [DAB_W-1:0]     dab2_r;
  logic [DL2_W-1:0]     dl2_3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_3_r  <= r1_r;
      r2_3_r  <= r2_r;
      dab2_r  <= DAB_W'(sda_r) + DAB_W'(sdb_r);
      dl2_3_r <= dl2_r;
    end
  end

  // ---------------- Chroma roots of both colors, side data delayed alongside
  logic [1:0][CRAD_W-1:0]   c_rad;
  logic [1:0][CHROMA_W-1:0] c_root;
  logic                     c_v;
  logic [DAB_W-1:0]         dab_dly_r [C_STAGES];
  logic [DL2_W-1:0]         dl2_dly_r [C_STAGES];

  assign c_rad[0] = r1_3_r;
  assign c_rad[1] = r2_3_r;

  cie94_sqrt_pipe #(
    .LANES (2),
    .RAD_W (CRAD_W)
  ) u_chroma_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v3_r),
    .radicand  (c_rad),
    .out_valid (c_v),
    .root      (c_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dab_dly_r[0] <= dab2_r;
      dl2_dly_r[0] <= dl2_3_r;
      for (int i = 1; i < C_STAGES; i++) begin
        dab_dly_r[i] <= dab_dly_r[i-1];
        dl2_dly_r[i] <= dl2_dly_r[i-1];
      end
    end
  end

  // ---------------- Stage 4: chroma difference, weight products
  logic                       v4_r;
  logic signed [DIFF_W-1:0]   dc_r;
  logic [PK_W-1:0]            pk1_r, pk2_r;
  logic [DAB_W-1:0]           dab2_4_r;
  logic [DL2_W-1:0]           dl2_4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dc_r     <= $signed({1'b0, c_root[0]}) - $signed({1'b0, c_root[1]});
      pk1_r    <= PK_W'(c_root[0]) * PK_W'(WEIGHT_K1);
      pk2_r    <= PK_W'(c_root[0]) * PK_W'(WEIGHT_K2);
      dab2_4_r <= dab_dly_r[C_STAGES-1];
      dl2_4_r  <= dl2_dly_r[C_STAGES-1];
    end
  end

  // ---------------- Stage 5: chroma difference squared, SC and SH
  logic                 v5_r;
  logic [DSQ_W-1:0]     dc2_r;
  logic [SW-1:0]        sc_r, sh_r;
  logic [DAB_W-1:0]     dab2_5_r;
  logic [DL2_W-1:0]     dl2_5_r;
  logic signed [33:0]   pdc;

  assign pdc = dc_r * dc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dc2_r    <= pdc[DSQ_W-1:0];
      sc_r     <= ONE_Q + SW'((pk1_r + WEIGHT_ROUND) >> WEIGHT_SHIFT);
      sh_r     <= ONE_Q + SW'((pk2_r + WEIGHT_ROUND) >> WEIGHT_SHIFT);
      dab2_5_r <= dab2_4_r;
      dl2_5_r  <= dl2_4_r;
    end
  end

  // ---------------- Stage 6: squared weights, hue remainder clamped at zero
  logic                 v6_r;
  logic [DSQ_W-1:0]     dc2_6_r;
  logic [DAB_W-1:0]     dh2_r;
  logic [DW-1:0]        sc2_r, sh2_r;
  logic [DL2_W-1:0]     dl2_6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dc2_6_r <= dc2_r;
      dh2_r   <= (dab2_5_r > DAB_W'(dc2_r)) ? (dab2_5_r - DAB_W'(dc2_r)) : '0;
      sc2_r   <= DW'(sc_r) * DW'(sc_r);
      sh2_r   <= DW'(sh_r) * DW'(sh_r);
      dl2_6_r <= dl2_5_r;
    end
  end

  // ---------------- Weighted chroma and hue terms
  logic [1:0][NW-1:0]    q_num;
  logic [1:0][DW-1:0]    q_den;
  logic [1:0][QUO_W-1:0] q_quo;
  logic                  q_v;
  logic [DL2_W-1:0]      dl2_q_r [QUO_W];

  assign q_num[0] = NW'(dc2_6_r) << (2 * FRAC_BITS);
  assign q_num[1] = NW'(dh2_r) << (2 * FRAC_BITS);
  assign q_den[0] = sc2_r;
  assign q_den[1] = sh2_r;

  cie94_div_pipe #(
    .LANES (2),
    .NUM_W (NW),
    .DEN_W (DW),
    .QUO_W (QUO_W)
  ) u_weight_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v6_r),
    .num       (q_num),
    .den       (q_den),
    .out_valid (q_v),
    .quotient  (q_quo)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2_q_r[0] <= dl2_6_r;
      for (int i = 1; i < QUO_W; i++) begin
        dl2_q_r[i] <= dl2_q_r[i-1];
      end
    end
  end

  // ---------------- Stage 7: sum of squares
  logic              v7_r;
  logic [SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= SUM_W'(dl2_q_r[QUO_W-1]) + SUM_W'(q_quo[0]) + SUM_W'(q_quo[1]);
    end
  end

  // Valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= c_v;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= q_v;
    end
  end

  // ---------------- Final root and saturation
  logic [0:0][SUM_W-1:0] e_rad;
  logic [0:0][E_W-1:0]   e_root;
  logic                  e_v;
  logic                  e_sat;
  logic [OUT_W-1:0]      e_word;

  assign e_rad[0] = sum_r;

  cie94_sqrt_pipe #(
    .LANES (1),
    .RAD_W (SUM_W)
  ) u_final_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v7_r),
    .radicand  (e_rad),
    .out_valid (e_v),
    .root      (e_root)
  );

  assign e_sat  = (e_root[0][E_W-1:OUT_W] != '0);
  assign e_word = e_sat ? '1 : e_root[0][OUT_W-1:0];

  // ---------------- Output register and skid register
  // The pipe hands its last word off at every advancing edge. It goes to the
  // output register when that is free or being taken, else into the skid
  // register, which then freezes the pipe until the output drains it.
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_delta_e_r;
  logic              out_saturated_r;
  logic [OUT_W-1:0]  skid_delta_e_r;
  logic              skid_saturated_r;
  logic              take;

  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      skid_v_r         <= 1'b0;
      out_delta_e_r    <= '0;
      out_saturated_r  <= 1'b0;
      skid_delta_e_r   <= '0;
      skid_saturated_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_delta_e_r   <= skid_delta_e_r;
        out_saturated_r <= skid_saturated_r;
        skid_v_r        <= 1'b0;
      end
    end else if (e_v) begin
      if (!out_valid_r || take) begin
        out_delta_e_r   <= e_word;
        out_saturated_r <= e_sat;
        out_valid_r     <= 1'b1;
      end else begin
        skid_delta_e_r   <= e_word;
        skid_saturated_r <= e_sat;
        skid_v_r         <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_delta_e   = out_delta_e_r;
  assign out_saturated = out_saturated_r;

  // ---------------- Assertions
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid register full while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_stall) |=> skid_v_r)
    else $error("skid word dropped under stall");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(e_v) && $stable(e_word))
    else $error("pipeline moved while frozen");

  a_sat_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_saturated_r) |-> (out_delta_e_r == '1))
    else $error("saturated word without full-scale value");

endmodule
